### sv/ssreg_pkg.sv
// Shared types and codes for the sorted slot registry.
// Holds request/result structs, entry layout, datapath op codes and status codes.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package ssreg_pkg;

    localparam int DEF_TABLE_DEPTH = 16;

    localparam logic [2:0] REQ_REGISTER  = 3'd0;
    localparam logic [2:0] REQ_HEARTBEAT = 3'd1;
    localparam logic [2:0] REQ_DELETE    = 3'd2;
    localparam logic [2:0] REQ_SWEEP     = 3'd3;
    localparam logic [2:0] REQ_LOOKUP    = 3'd4;

    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_NOT_FOUND = 2'd1;
    localparam logic [1:0] ST_FULL      = 2'd2;
    localparam logic [1:0] ST_STALE     = 2'd3;

    typedef struct packed {
        logic [2:0]  req_type;
        logic [7:0]  slot_id;
        logic [7:0]  slot_state;
        logic [63:0] uptime;
    } req_t;

    typedef struct packed {
        logic [1:0]  status;
        logic [3:0]  position;
        logic [4:0]  board_count;
        logic [7:0]  found_slot;
        logic [7:0]  found_state;
        logic [63:0] found_uptime;
    } rsp_t;

    typedef struct packed {
        logic [7:0]  slot;
        logic [7:0]  state;
        logic [63:0] uptime;
        logic        stale;
    } entry_t;

    typedef enum logic [4:0] {
        DP_NOP,
        DP_LOAD,
        DP_SRCH_RD,
        DP_SRCH_CMP,
        DP_PUT,
        DP_FULL,
        DP_MISS,
        DP_INS_PREP,
        DP_SHU_RD,
        DP_SHU_WR,
        DP_DEL_PREP,
        DP_SHD_RD,
        DP_SHD_WR,
        DP_DEL_END,
        DP_LOOK,
        DP_SWP_RD,
        DP_SWP_WR,
        DP_OUT
    } dp_op_t;

    typedef struct packed {
        logic [2:0] req_type;
        logic       srch_done;
        logic       hit;
        logic       full;
        logic       shu_more;
        logic       shd_more;
        logic       swp_more;
        logic       swp_stale;
    } dp_sts_t;

endpackage

`default_nettype wire

### sv/ssreg_dp.sv
// Datapath of the sorted slot registry: entry memory, count, search bounds,
// shift pointer, result holding and output registers.
// Depends on ssreg_pkg.
`timescale 1ns / 1ps
`default_nettype none

module ssreg_dp import ssreg_pkg::*; #(
    parameter int TABLE_DEPTH = DEF_TABLE_DEPTH
) (
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire dp_op_t     op,
    output dp_sts_t         sts,
    input  wire req_t       s_data,
    output rsp_t            m_data,
    input  wire logic       cfg_we,
    input  wire logic [7:0] cfg_data
);

    localparam int IDX_W = $clog2(TABLE_DEPTH);
    localparam int CNT_W = $clog2(TABLE_DEPTH + 1);

    entry_t mem [TABLE_DEPTH];
    entry_t rd_data_reg;

    req_t             req_reg;
    logic [CNT_W-1:0] count_reg, count_next;
    logic [CNT_W-1:0] lo_reg, lo_next;
    logic [CNT_W-1:0] hi_reg, hi_next;
    logic [CNT_W-1:0] pos_reg, pos_next;
    logic [CNT_W-1:0] ptr_reg, ptr_next;
    logic             hit_reg, hit_next;
    logic [1:0]       status_reg, status_next;
    logic [CNT_W-1:0] rpos_reg, rpos_next;
    entry_t           fnd_reg, fnd_next;
    rsp_t             m_data_reg;
    logic [7:0]       offline_reg;

    logic [CNT_W-1:0] mid;
    logic [CNT_W-1:0] ptr_dec;
    logic [CNT_W-1:0] ptr_inc;
    logic             rd_en;
    logic [IDX_W-1:0] rd_addr;
    logic             wr_en;
    logic [IDX_W-1:0] wr_addr;
    entry_t           wr_data;
    entry_t           new_entry;
    entry_t           swp_entry;

    assign mid     = lo_reg + ((hi_reg - lo_reg) >> 1);
    assign ptr_dec = ptr_reg - 1'b1;
    assign ptr_inc = ptr_reg + 1'b1;

    assign new_entry = '{slot: req_reg.slot_id, state: req_reg.slot_state,
                         uptime: req_reg.uptime, stale: 1'b0};

    always_comb begin
        swp_entry = rd_data_reg;
        if (rd_data_reg.stale) begin
            swp_entry.state = offline_reg;
        end else begin
            swp_entry.stale = 1'b1;
        end
    end

    always_comb begin
        sts.req_type  = req_reg.req_type;
        sts.srch_done = hit_reg || (lo_reg >= hi_reg);
        sts.hit       = hit_reg;
        sts.full      = (count_reg == CNT_W'(TABLE_DEPTH));
        sts.shu_more  = (ptr_reg > pos_reg);
        sts.shd_more  = ({1'b0, ptr_reg} + 1'b1) < {1'b0, count_reg};
        sts.swp_more  = (ptr_reg < count_reg);
        sts.swp_stale = rd_data_reg.stale;
    end

    always_comb begin
        rd_en       = 1'b0;
        rd_addr     = ptr_reg[IDX_W-1:0];
        wr_en       = 1'b0;
        wr_addr     = ptr_reg[IDX_W-1:0];
        wr_data     = rd_data_reg;
        count_next  = count_reg;
        lo_next     = lo_reg;
        hi_next     = hi_reg;
        pos_next    = pos_reg;
        ptr_next    = ptr_reg;
        hit_next    = hit_reg;
        status_next = status_reg;
        rpos_next   = rpos_reg;
        fnd_next    = fnd_reg;
        case (op)
            DP_LOAD: begin
                lo_next     = '0;
                hi_next     = count_reg;
                pos_next    = '0;
                ptr_next    = '0;
                hit_next    = 1'b0;
                status_next = ST_OK;
                rpos_next   = '0;
                fnd_next    = '0;
            end
            DP_SRCH_RD: begin
                rd_en   = 1'b1;
                rd_addr = mid[IDX_W-1:0];
            end
            DP_SRCH_CMP: begin
                if (rd_data_reg.slot == req_reg.slot_id) begin
                    hit_next = 1'b1;
                    pos_next = mid;
                end else if (rd_data_reg.slot > req_reg.slot_id) begin
                    hi_next = mid;
                end else begin
                    lo_next  = mid + 1'b1;
                    pos_next = mid + 1'b1;
                end
            end
            DP_PUT: begin
                wr_en     = 1'b1;
                wr_addr   = pos_reg[IDX_W-1:0];
                wr_data   = new_entry;
                fnd_next  = new_entry;
                rpos_next = pos_reg;
                if (!hit_reg) begin
                    count_next = count_reg + 1'b1;
                end
            end
            DP_FULL: begin
                status_next = ST_FULL;
            end
            DP_MISS: begin
                status_next = ST_NOT_FOUND;
            end
            DP_INS_PREP: begin
                ptr_next = count_reg;
            end
            DP_SHU_RD: begin
                rd_en   = 1'b1;
                rd_addr = ptr_dec[IDX_W-1:0];
            end
            DP_SHU_WR: begin
                wr_en    = 1'b1;
                ptr_next = ptr_dec;
            end
            DP_DEL_PREP: begin
                fnd_next  = rd_data_reg;
                rpos_next = pos_reg;
                ptr_next  = pos_reg;
            end
            DP_SHD_RD: begin
                rd_en   = 1'b1;
                rd_addr = ptr_inc[IDX_W-1:0];
            end
            DP_SHD_WR: begin
                wr_en    = 1'b1;
                ptr_next = ptr_inc;
            end
            DP_DEL_END: begin
                count_next = count_reg - 1'b1;
            end
            DP_LOOK: begin
                fnd_next  = rd_data_reg;
                rpos_next = pos_reg;
            end
            DP_SWP_RD: begin
                rd_en = 1'b1;
            end
            DP_SWP_WR: begin
                wr_en   = 1'b1;
                wr_data = swp_entry;
                if (rd_data_reg.stale) begin
                    status_next = ST_STALE;
                    rpos_next   = ptr_reg;
                    fnd_next    = swp_entry;
                end else begin
                    ptr_next = ptr_inc;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg   <= '0;
            offline_reg <= '0;
        end else begin
            count_reg <= count_next;
            if (cfg_we) begin
                offline_reg <= cfg_data;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (op == DP_LOAD) begin
            req_reg <= s_data;
        end
        lo_reg     <= lo_next;
        hi_reg     <= hi_next;
        pos_reg    <= pos_next;
        ptr_reg    <= ptr_next;
        hit_reg    <= hit_next;
        status_reg <= status_next;
        rpos_reg   <= rpos_next;
        fnd_reg    <= fnd_next;
        if (op == DP_OUT) begin
            m_data_reg.status       <= status_reg;
            m_data_reg.position     <= 4'(rpos_reg);
            m_data_reg.board_count  <= 5'(count_reg);
            m_data_reg.found_slot   <= fnd_reg.slot;
            m_data_reg.found_state  <= fnd_reg.state;
            m_data_reg.found_uptime <= fnd_reg.uptime;
        end
    end

    assign m_data = m_data_reg;

`ifndef SYNTH
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CNT_W'(TABLE_DEPTH))
        else $error("entry count above table depth");

    a_insert_grows: assert property (@(posedge aclk) disable iff (!aresetn)
        (op == DP_PUT && !hit_reg) |=> count_reg == $past(count_reg) + 1'b1)
        else $error("insert did not grow the table");

    a_no_full_insert: assert property (@(posedge aclk) disable iff (!aresetn)
        op == DP_INS_PREP |-> count_reg < CNT_W'(TABLE_DEPTH))
        else $error("insert started on a full table");
`endif

endmodule

`default_nettype wire

### sv/ssreg_ctrl.sv
// Controller of the sorted slot registry: sequences search, shift and sweep
// steps of the datapath and owns both handshakes.
// Depends on ssreg_pkg.
`timescale 1ns / 1ps
`default_nettype none

module ssreg_ctrl import ssreg_pkg::*; (
    input  wire logic    aclk,
    input  wire logic    aresetn,
    input  wire logic    s_valid,
    output logic         s_ready,
    output logic         m_valid,
    input  wire logic    m_ready,
    output dp_op_t       op,
    input  wire dp_sts_t sts
);

    typedef enum logic [3:0] {
        CS_IDLE,
        CS_DECODE,
        CS_SRCH_CHK,
        CS_SRCH_CMP,
        CS_SHU_CHK,
        CS_SHU_WR,
        CS_SHD_CHK,
        CS_SHD_WR,
        CS_SWP_CHK,
        CS_SWP_WR,
        CS_FINISH
    } state_t;

    state_t state_reg, state_next;
    logic   m_valid_reg, m_valid_next;

    assign s_ready = (state_reg == CS_IDLE);
    assign m_valid = m_valid_reg;

    always_comb begin
        state_next   = state_reg;
        m_valid_next = m_valid_reg && !m_ready;
        op           = DP_NOP;
        case (state_reg)
            CS_IDLE: begin
                if (s_valid) begin
                    op         = DP_LOAD;
                    state_next = CS_DECODE;
                end
            end
            CS_DECODE: begin
                if (sts.req_type inside {REQ_REGISTER, REQ_HEARTBEAT, REQ_DELETE,
                                         REQ_LOOKUP}) begin
                    state_next = CS_SRCH_CHK;
                end else if (sts.req_type == REQ_SWEEP) begin
                    state_next = CS_SWP_CHK;
                end else begin
                    state_next = CS_FINISH;
                end
            end
            CS_SRCH_CHK: begin
                if (!sts.srch_done) begin
                    op         = DP_SRCH_RD;
                    state_next = CS_SRCH_CMP;
                end else if (sts.hit) begin
                    case (sts.req_type)
                        REQ_REGISTER, REQ_HEARTBEAT: begin
                            op         = DP_PUT;
                            state_next = CS_FINISH;
                        end
                        REQ_DELETE: begin
                            op         = DP_DEL_PREP;
                            state_next = CS_SHD_CHK;
                        end
                        default: begin
                            op         = DP_LOOK;
                            state_next = CS_FINISH;
                        end
                    endcase
                end else if (sts.req_type == REQ_REGISTER) begin
                    if (sts.full) begin
                        op         = DP_FULL;
                        state_next = CS_FINISH;
                    end else begin
                        op         = DP_INS_PREP;
                        state_next = CS_SHU_CHK;
                    end
                end else begin
                    op         = DP_MISS;
                    state_next = CS_FINISH;
                end
            end
            CS_SRCH_CMP: begin
                op         = DP_SRCH_CMP;
                state_next = CS_SRCH_CHK;
            end
            CS_SHU_CHK: begin
                if (sts.shu_more) begin
                    op         = DP_SHU_RD;
                    state_next = CS_SHU_WR;
                end else begin
                    op         = DP_PUT;
                    state_next = CS_FINISH;
                end
            end
            CS_SHU_WR: begin
                op         = DP_SHU_WR;
                state_next = CS_SHU_CHK;
            end
            CS_SHD_CHK: begin
                if (sts.shd_more) begin
                    op         = DP_SHD_RD;
                    state_next = CS_SHD_WR;
                end else begin
                    op         = DP_DEL_END;
                    state_next = CS_FINISH;
                end
            end
            CS_SHD_WR: begin
                op         = DP_SHD_WR;
                state_next = CS_SHD_CHK;
            end
            CS_SWP_CHK: begin
                if (sts.swp_more) begin
                    op         = DP_SWP_RD;
                    state_next = CS_SWP_WR;
                end else begin
                    state_next = CS_FINISH;
                end
            end
            CS_SWP_WR: begin
                op = DP_SWP_WR;
                if (sts.swp_stale) begin
                    state_next = CS_FINISH;
                end else begin
                    state_next = CS_SWP_CHK;
                end
            end
            CS_FINISH: begin
                if (!m_valid_reg || m_ready) begin
                    op           = DP_OUT;
                    m_valid_next = 1'b1;
                    state_next   = CS_IDLE;
                end
            end
            default: begin
                state_next = CS_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= CS_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

`ifndef SYNTH
    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> !s_ready)
        else $error("new item taken while one is in progress");

    a_no_result_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        op == DP_OUT |-> (!m_valid_reg || m_ready))
        else $error("pending result overwritten");
`endif

endmodule

`default_nettype wire

### sv/sorted_slot_registry_with_liveness.sv
// Sorted slot registry with liveness sweep: top level joining controller and datapath.
// A request is decoded, then binary-searched, shifted or swept as its type needs; shifts and
// sweeps read and then write each entry through the entry memory.
// A new item is taken only when idle, once the previous result has been loaded into the output register.
// Reset: synchronous, active low; clears count, offline code and handshake state.
`timescale 1ns / 1ps
`default_nettype none

module sorted_slot_registry_with_liveness import ssreg_pkg::*; #(
    parameter int TABLE_DEPTH = DEF_TABLE_DEPTH
) (
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic       s_valid,
    output logic            s_ready,
    input  wire req_t       s_data,
    output logic            m_valid,
    input  wire logic       m_ready,
    output rsp_t            m_data,
    input  wire logic       cfg_valid,
    output logic            cfg_ready,
    input  wire logic [7:0] cfg_data
);

    dp_op_t  op;
    dp_sts_t sts;

    assign cfg_ready = 1'b1;

    ssreg_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .op      (op),
        .sts     (sts)
    );

    ssreg_dp #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_dp (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .op       (op),
        .sts      (sts),
        .s_data   (s_data),
        .m_data   (m_data),
        .cfg_we   (cfg_valid && cfg_ready),
        .cfg_data (cfg_data)
    );

endmodule

`default_nettype wire
